[src/prim_minimum_spanning_tree_unit_assert.svh]
// Assertion macros for the spanning tree unit.
// Both macros are empty when SYNTHESIS is defined.
`ifndef PRIM_MINIMUM_SPANNING_TREE_UNIT_ASSERT_SVH
`define PRIM_MINIMUM_SPANNING_TREE_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// The consequent must hold in the same cycle as the antecedent.
`define MST_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
// The consequent must hold in the cycle after the antecedent.
`define MST_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define MST_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define MST_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[src/mst_pkg.sv]
package mst_pkg;

    // Graph size and cost width.
    localparam int MAX_VERTICES = 32;
    localparam int COST_BITS    = 16;
    localparam int VERTEX_BITS  = $clog2(MAX_VERTICES);
    localparam int COUNT_BITS   = VERTEX_BITS + 1;
    localparam int KEY_BITS     = COST_BITS + 1;
    localparam int ADDR_BITS    = 2 * VERTEX_BITS;
    localparam int TOTAL_BITS   = 21;
    localparam int VCOUNT_BITS  = 6;

    // A cost with the top bit set means there is no edge.
    localparam logic [KEY_BITS-1:0] NO_EDGE = {1'b1, {COST_BITS{1'b0}}};

    // Item modes.
    localparam logic [1:0] MODE_CLEAR = 2'd0;
    localparam logic [1:0] MODE_ADD   = 2'd1;
    localparam logic [1:0] MODE_RUN   = 2'd2;

    // Configuration register map.
    localparam int                 PADDR_BITS        = 3;
    localparam int                 PDATA_BITS        = 32;
    localparam logic [PADDR_BITS-1:0] ADDR_VERTEX_COUNT = 3'd0;
    localparam logic [VCOUNT_BITS-1:0] VCOUNT_RESET   = 6'd32;

    // One input item.
    typedef struct packed {
        logic [1:0]             mode;
        logic [VERTEX_BITS-1:0] vertex_a;
        logic [VERTEX_BITS-1:0] vertex_b;
        logic [COST_BITS-1:0]   edge_cost;
    } t_mst_item;

    // One result item.
    typedef struct packed {
        logic                   edge_valid;
        logic [VERTEX_BITS-1:0] parent_vertex;
        logic [VERTEX_BITS-1:0] child_vertex;
        logic [COST_BITS-1:0]   tree_edge_cost;
        logic [TOTAL_BITS-1:0]  total_cost;
        logic                   connected;
        logic                   last;
    } t_mst_result;

endpackage

[src/mst_cost_ram.sv]
module mst_cost_ram
    import mst_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [ADDR_BITS-1:0] i_waddr,
    input  logic [KEY_BITS-1:0]  i_wdata,
    input  logic [ADDR_BITS-1:0] i_raddr,
    output logic [KEY_BITS-1:0]  o_rdata
);

    localparam int DEPTH = MAX_VERTICES * MAX_VERTICES;

    logic [KEY_BITS-1:0] r_mem [DEPTH];
    logic [KEY_BITS-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[src/mst_engine.sv]
module mst_engine
    import mst_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  t_mst_item              i_item,
    input  logic [VCOUNT_BITS-1:0] i_vertex_count,
    output logic                   o_busy,
    output logic                   o_res_valid,
    input  logic                   i_res_ready,
    output t_mst_result            o_res
);

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ADD_RD,
        ST_ADD_CMP,
        ST_ADD_WR2,
        ST_INIT,
        ST_MIN_SCAN,
        ST_PICK,
        ST_UPD_SCAN,
        ST_SUM,
        ST_EMIT
    } t_state;

    // Sequencer registers.
    t_state                 r_state, n_state;
    logic [ADDR_BITS-1:0]   r_clr_addr, n_clr_addr;
    logic [VERTEX_BITS-1:0] r_a, n_a;
    logic [VERTEX_BITS-1:0] r_b, n_b;
    logic [COST_BITS-1:0]   r_cost, n_cost;
    logic [COUNT_BITS-1:0]  r_v, n_v;
    logic [VERTEX_BITS-1:0] r_u, n_u;
    logic                   r_found, n_found;
    logic [VERTEX_BITS-1:0] r_best, n_best;
    logic [KEY_BITS-1:0]    r_best_key, n_best_key;
    logic                   r_have_free, n_have_free;
    logic [VERTEX_BITS-1:0] r_free, n_free;
    logic                   r_upd_valid, n_upd_valid;
    logic [VERTEX_BITS-1:0] r_upd_v, n_upd_v;
    logic [COUNT_BITS-1:0]  r_edges, n_edges;
    logic [TOTAL_BITS-1:0]  r_total, n_total;
    logic [COUNT_BITS-1:0]  r_k, n_k;

    // Per-vertex run state.
    logic [KEY_BITS-1:0]    r_key [MAX_VERTICES];
    logic [VERTEX_BITS-1:0] r_parent [MAX_VERTICES];
    logic [MAX_VERTICES-1:0] r_has_parent;
    logic [MAX_VERTICES-1:0] r_in_tree;

    // Cost matrix port.
    logic                   w_ram_we;
    logic [ADDR_BITS-1:0]   w_ram_waddr;
    logic [KEY_BITS-1:0]    w_ram_wdata;
    logic [ADDR_BITS-1:0]   w_ram_raddr;
    logic [KEY_BITS-1:0]    w_ram_rdata;

    // Run state access.
    logic [VERTEX_BITS-1:0] w_ridx;
    logic [KEY_BITS-1:0]    w_key_rd;
    logic                   w_clr_run;
    logic                   w_key_we;
    logic                   w_par_we;
    logic                   w_tree_set;
    logic [VERTEX_BITS-1:0] w_widx;
    logic [KEY_BITS-1:0]    w_key_wdata;

    // Shared comparator.
    logic [KEY_BITS-1:0]    w_cmp_a;
    logic [KEY_BITS-1:0]    w_cmp_b;
    logic                   w_cmp_lt;

    logic [COUNT_BITS-1:0]  w_n;
    logic [COUNT_BITS-1:0]  w_n_last;
    logic [VERTEX_BITS-1:0] w_vidx;

    mst_cost_ram u_cost_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    // Effective vertex count: zero counts as one, large values saturate.
    always_comb begin
        if (i_vertex_count == '0) begin
            w_n = COUNT_BITS'(1);
        end else if (COUNT_BITS'(i_vertex_count) > COUNT_BITS'(MAX_VERTICES)) begin
            w_n = COUNT_BITS'(MAX_VERTICES);
        end else begin
            w_n = COUNT_BITS'(i_vertex_count);
        end
    end

    assign w_n_last = w_n - COUNT_BITS'(1);
    assign w_vidx   = r_v[VERTEX_BITS-1:0];

    // Run state read index follows the active scan.
    assign w_ridx   = (r_state == ST_UPD_SCAN) ? r_upd_v : w_vidx;
    assign w_key_rd = r_key[w_ridx];

    // Comparator operands per phase.
    always_comb begin
        unique case (r_state)
            ST_ADD_CMP: begin
                w_cmp_a = {1'b0, r_cost};
                w_cmp_b = w_ram_rdata;
            end
            ST_MIN_SCAN: begin
                w_cmp_a = w_key_rd;
                w_cmp_b = r_best_key;
            end
            ST_UPD_SCAN: begin
                w_cmp_a = w_ram_rdata;
                w_cmp_b = w_key_rd;
            end
            default: begin
                w_cmp_a = '0;
                w_cmp_b = '0;
            end
        endcase
    end

    assign w_cmp_lt = w_cmp_a < w_cmp_b;

    // Sequencer next state.
    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_a         = r_a;
        n_b         = r_b;
        n_cost      = r_cost;
        n_v         = r_v;
        n_u         = r_u;
        n_found     = r_found;
        n_best      = r_best;
        n_best_key  = r_best_key;
        n_have_free = r_have_free;
        n_free      = r_free;
        n_upd_valid = r_upd_valid;
        n_upd_v     = r_upd_v;
        n_edges     = r_edges;
        n_total     = r_total;
        n_k         = r_k;
        w_ram_we    = 1'b0;
        w_ram_waddr = '0;
        w_ram_wdata = NO_EDGE;
        w_ram_raddr = '0;
        w_clr_run   = 1'b0;
        w_key_we    = 1'b0;
        w_par_we    = 1'b0;
        w_tree_set  = 1'b0;
        w_widx      = '0;
        w_key_wdata = '0;
        o_res_valid = 1'b0;
        o_res       = '0;

        unique case (r_state)
            // Sweep the whole matrix to no edge.
            ST_CLEAR: begin
                w_ram_we    = 1'b1;
                w_ram_waddr = r_clr_addr;
                n_clr_addr  = r_clr_addr + ADDR_BITS'(1);
                if (r_clr_addr == '1) begin
                    n_state = ST_IDLE;
                end
            end
            // Wait for an item and decode its mode.
            ST_IDLE: begin
                if (i_start) begin
                    unique case (i_item.mode)
                        MODE_CLEAR: begin
                            n_clr_addr = '0;
                            n_state    = ST_CLEAR;
                        end
                        MODE_ADD: begin
                            n_a    = i_item.vertex_a;
                            n_b    = i_item.vertex_b;
                            n_cost = i_item.edge_cost;
                            if (i_item.vertex_a != i_item.vertex_b) begin
                                n_state = ST_ADD_RD;
                            end
                        end
                        MODE_RUN: begin
                            n_state = ST_INIT;
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            // Read the stored cost of the pair.
            ST_ADD_RD: begin
                w_ram_raddr = {r_a, r_b};
                n_state     = ST_ADD_CMP;
            end
            // Keep the lower cost; write both halves of the symmetric pair.
            ST_ADD_CMP: begin
                if (w_cmp_lt) begin
                    w_ram_we    = 1'b1;
                    w_ram_waddr = {r_a, r_b};
                    w_ram_wdata = {1'b0, r_cost};
                    n_state     = ST_ADD_WR2;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_ADD_WR2: begin
                w_ram_we    = 1'b1;
                w_ram_waddr = {r_b, r_a};
                w_ram_wdata = {1'b0, r_cost};
                n_state     = ST_IDLE;
            end
            // Reset keys, parents and tree membership.
            ST_INIT: begin
                w_clr_run   = 1'b1;
                n_v         = '0;
                n_found     = 1'b0;
                n_have_free = 1'b0;
                n_state     = ST_MIN_SCAN;
            end
            // Find the least finite key and the lowest unvisited vertex.
            ST_MIN_SCAN: begin
                if (!r_in_tree[w_vidx]) begin
                    if (!r_have_free) begin
                        n_have_free = 1'b1;
                        n_free      = w_vidx;
                    end
                    if (!w_key_rd[COST_BITS] && (!r_found || w_cmp_lt)) begin
                        n_found    = 1'b1;
                        n_best     = w_vidx;
                        n_best_key = w_key_rd;
                    end
                end
                if (r_v == w_n_last) begin
                    n_state = ST_PICK;
                end else begin
                    n_v = r_v + COUNT_BITS'(1);
                end
            end
            // Add the chosen vertex, or restart at the lowest unvisited one.
            ST_PICK: begin
                n_v         = '0;
                n_upd_valid = 1'b0;
                if (r_found) begin
                    n_u        = r_best;
                    w_tree_set = 1'b1;
                    w_widx     = r_best;
                    n_state    = ST_UPD_SCAN;
                end else if (r_have_free) begin
                    n_u         = r_free;
                    w_tree_set  = 1'b1;
                    w_key_we    = 1'b1;
                    w_widx      = r_free;
                    w_key_wdata = '0;
                    n_state     = ST_UPD_SCAN;
                end else begin
                    n_edges = '0;
                    n_total = '0;
                    n_state = ST_SUM;
                end
            end
            // Walk row u of the matrix; relax each key in the cycle after its read.
            ST_UPD_SCAN: begin
                w_ram_raddr = {r_u, w_vidx};
                n_upd_valid = (r_v != w_n);
                n_upd_v     = w_vidx;
                if (r_upd_valid && !r_in_tree[r_upd_v] && !w_ram_rdata[COST_BITS] &&
                    w_cmp_lt) begin
                    w_key_we    = 1'b1;
                    w_par_we    = 1'b1;
                    w_widx      = r_upd_v;
                    w_key_wdata = w_ram_rdata;
                end
                if (r_v == w_n) begin
                    n_v         = '0;
                    n_found     = 1'b0;
                    n_have_free = 1'b0;
                    n_upd_valid = 1'b0;
                    n_state     = ST_MIN_SCAN;
                end else begin
                    n_v = r_v + COUNT_BITS'(1);
                end
            end
            // Count tree edges and add up their costs.
            ST_SUM: begin
                if (r_has_parent[w_vidx]) begin
                    n_edges = r_edges + COUNT_BITS'(1);
                    n_total = r_total + TOTAL_BITS'(w_key_rd[COST_BITS-1:0]);
                end
                if (r_v == w_n_last) begin
                    n_v     = '0;
                    n_k     = '0;
                    n_state = ST_EMIT;
                end else begin
                    n_v = r_v + COUNT_BITS'(1);
                end
            end
            // Emit edges in ascending child order, or one empty result.
            ST_EMIT: begin
                o_res.connected = ((r_edges + COUNT_BITS'(1)) == w_n);
                if (r_edges == '0) begin
                    o_res_valid = 1'b1;
                    o_res.last  = 1'b1;
                    if (i_res_ready) begin
                        n_state = ST_IDLE;
                    end
                end else if (r_has_parent[w_vidx]) begin
                    o_res_valid          = 1'b1;
                    o_res.edge_valid     = 1'b1;
                    o_res.parent_vertex  = r_parent[w_vidx];
                    o_res.child_vertex   = w_vidx;
                    o_res.tree_edge_cost = w_key_rd[COST_BITS-1:0];
                    o_res.total_cost     = r_total;
                    o_res.last           = ((r_k + COUNT_BITS'(1)) == r_edges);
                    if (i_res_ready) begin
                        n_k = r_k + COUNT_BITS'(1);
                        n_v = r_v + COUNT_BITS'(1);
                        if (o_res.last) begin
                            n_state = ST_IDLE;
                        end
                    end
                end else begin
                    n_v = r_v + COUNT_BITS'(1);
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Sequencer state; the matrix sweep starts right after reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_v         <= '0;
            r_found     <= 1'b0;
            r_have_free <= 1'b0;
            r_upd_valid <= 1'b0;
            r_edges     <= '0;
            r_k         <= '0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_v         <= n_v;
            r_found     <= n_found;
            r_have_free <= n_have_free;
            r_upd_valid <= n_upd_valid;
            r_edges     <= n_edges;
            r_k         <= n_k;
        end
        r_a        <= n_a;
        r_b        <= n_b;
        r_cost     <= n_cost;
        r_u        <= n_u;
        r_best     <= n_best;
        r_best_key <= n_best_key;
        r_free     <= n_free;
        r_upd_v    <= n_upd_v;
        r_total    <= n_total;
    end

    // Per-vertex keys, parents and flags.
    always_ff @(posedge i_clk) begin
        if (w_clr_run) begin
            for (int i = 0; i < MAX_VERTICES; i++) begin
                r_key[i] <= NO_EDGE;
            end
            r_in_tree    <= '0;
            r_has_parent <= '0;
        end else begin
            if (w_key_we) begin
                r_key[w_widx] <= w_key_wdata;
            end
            if (w_par_we) begin
                r_parent[w_widx]     <= r_u;
                r_has_parent[w_widx] <= 1'b1;
            end
            if (w_tree_set) begin
                r_in_tree[w_widx] <= 1'b1;
            end
        end
    end

    assign o_busy = (r_state != ST_IDLE);

endmodule

[src/prim_minimum_spanning_tree_unit.sv]
// Reset clears the cost matrix in a sweep of the whole matrix, and a clear item runs the same pass;
// no item is taken meanwhile. The vertex count register resets to 32.
// An add-edge item stalls the input after it is taken for its steps (read, compare with the
// first write, second write), without the second write when the stored cost is kept, and
// not at all for a self loop. A run item scans rows of the cost matrix through its single
// read port; results leave at up to one per cycle while the receiver does not stall.
`include "prim_minimum_spanning_tree_unit_assert.svh"

module prim_minimum_spanning_tree_unit
    import mst_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Configuration port.
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [PADDR_BITS-1:0]  paddr,
    input  logic [PDATA_BITS-1:0]  pwdata,
    output logic [PDATA_BITS-1:0]  prdata,
    output logic                   pready,
    // Input channel.
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic [1:0]             i_mode,
    input  logic [VERTEX_BITS-1:0] i_vertex_a,
    input  logic [VERTEX_BITS-1:0] i_vertex_b,
    input  logic [COST_BITS-1:0]   i_edge_cost,
    // Output channel.
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic                   o_edge_valid,
    output logic [VERTEX_BITS-1:0] o_parent_vertex,
    output logic [VERTEX_BITS-1:0] o_child_vertex,
    output logic [COST_BITS-1:0]   o_tree_edge_cost,
    output logic [TOTAL_BITS-1:0]  o_total_cost,
    output logic                   o_connected,
    output logic                   o_last
);

    logic [VCOUNT_BITS-1:0] r_vertex_count;
    logic                   r_out_valid;
    t_mst_result            r_out;

    logic                   w_busy;
    logic                   w_in_acc;
    t_mst_item              w_item;
    logic                   w_res_valid;
    logic                   w_res_ready;
    t_mst_result            w_res;
    logic                   w_cfg_wr;

    // Configuration register.
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign prdata   = (paddr == ADDR_VERTEX_COUNT) ?
                      PDATA_BITS'(r_vertex_count) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vertex_count <= VCOUNT_RESET;
        end else if (w_cfg_wr && (paddr == ADDR_VERTEX_COUNT)) begin
            r_vertex_count <= pwdata[VCOUNT_BITS-1:0];
        end
    end

    // Input handshake.
    assign o_in_stall        = w_busy;
    assign w_in_acc          = i_in_valid && !o_in_stall;
    assign w_item.mode       = i_mode;
    assign w_item.vertex_a   = i_vertex_a;
    assign w_item.vertex_b   = i_vertex_b;
    assign w_item.edge_cost  = i_edge_cost;

    mst_engine u_engine (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (w_in_acc),
        .i_item         (w_item),
        .i_vertex_count (r_vertex_count),
        .o_busy         (w_busy),
        .o_res_valid    (w_res_valid),
        .i_res_ready    (w_res_ready),
        .o_res          (w_res)
    );

    // Output register; it loads whenever empty or being drained.
    assign w_res_ready = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_ready) begin
            r_out_valid <= w_res_valid;
        end
        if (w_res_ready && w_res_valid) begin
            r_out <= w_res;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_edge_valid     = r_out.edge_valid;
    assign o_parent_vertex  = r_out.parent_vertex;
    assign o_child_vertex   = r_out.child_vertex;
    assign o_tree_edge_cost = r_out.tree_edge_cost;
    assign o_total_cost     = r_out.total_cost;
    assign o_connected      = r_out.connected;
    assign o_last           = r_out.last;

    // A run item keeps the block busy on the following cycle.
    `MST_ASSERT_NEXT(a_run_busy, i_clk, i_rst_n, w_in_acc && (i_mode == MODE_RUN), w_busy)
    // A result handed over is held in the output register next cycle.
    `MST_ASSERT_NEXT(a_res_loaded, i_clk, i_rst_n, w_res_valid && w_res_ready, r_out_valid)
    // The empty-forest result is always the last one and carries no cost.
    `MST_ASSERT_SAME(a_empty_last, i_clk, i_rst_n, r_out_valid && !r_out.edge_valid,
                     r_out.last && (r_out.total_cost == '0))

endmodule

[verif/mst_checker.sv]
`timescale 1ns / 1ps

// Watches both channels and the configuration port of the spanning tree unit,
// predicts the tree edges of every run item and compares them with the results.
module mst_checker
    import mst_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [PADDR_BITS-1:0]  paddr,
    input  logic [PDATA_BITS-1:0]  pwdata,
    input  logic                   pready,
    input  logic                   i_in_valid,
    input  logic                   o_in_stall,
    input  logic [1:0]             i_mode,
    input  logic [VERTEX_BITS-1:0] i_vertex_a,
    input  logic [VERTEX_BITS-1:0] i_vertex_b,
    input  logic [COST_BITS-1:0]   i_edge_cost,
    input  logic                   o_out_valid,
    input  logic                   i_out_stall,
    input  logic                   o_edge_valid,
    input  logic [VERTEX_BITS-1:0] o_parent_vertex,
    input  logic [VERTEX_BITS-1:0] o_child_vertex,
    input  logic [COST_BITS-1:0]   o_tree_edge_cost,
    input  logic [TOTAL_BITS-1:0]  o_total_cost,
    input  logic                   o_connected,
    input  logic                   o_last,
    output int                     o_fail_count,
    output int                     o_pending,
    output int                     o_results_seen
);

    // Shadow copy of the graph and of the vertex count register.
    logic [KEY_BITS-1:0]    graph_cost [MAX_VERTICES][MAX_VERTICES];
    logic [VCOUNT_BITS-1:0] vertex_count_reg;

    // Tree edges predicted but not yet seen on the output channel.
    t_mst_result tree_edges_due [$];

    function automatic void wipe_graph();
        int r;
        int c;
        for (r = 0; r < MAX_VERTICES; r++)
            for (c = 0; c < MAX_VERTICES; c++)
                graph_cost[r][c] = NO_EDGE;
    endfunction

    // Dense Prim over the vertices in use; queues one result per tree edge,
    // or a single empty result when the forest has no edges.
    function automatic void grow_forest();
        int n;
        int pass_no;
        int v;
        int u;
        int best;
        int edges;
        int k;
        int total;
        bit found;
        bit conn;
        logic [KEY_BITS-1:0]    key [MAX_VERTICES];
        logic [VERTEX_BITS-1:0] parent [MAX_VERTICES];
        bit                     has_parent [MAX_VERTICES];
        bit                     in_tree [MAX_VERTICES];
        t_mst_result            r;

        if (vertex_count_reg == 0)
            n = 1;
        else if (vertex_count_reg > MAX_VERTICES)
            n = MAX_VERTICES;
        else
            n = int'(vertex_count_reg);

        for (v = 0; v < MAX_VERTICES; v++) begin
            key[v]        = NO_EDGE;
            parent[v]     = '0;
            has_parent[v] = 1'b0;
            in_tree[v]    = 1'b0;
        end

        for (pass_no = 0; pass_no < n; pass_no++) begin
            found = 1'b0;
            best  = 0;
            for (v = 0; v < n; v++) begin
                if (!in_tree[v] && key[v] < NO_EDGE && (!found || key[v] < key[best])) begin
                    best  = v;
                    found = 1'b1;
                end
            end
            // No finite key left: start a new tree at the lowest unvisited vertex.
            if (!found) begin
                best = n;
                for (v = n - 1; v >= 0; v--)
                    if (!in_tree[v])
                        best = v;
                if (best == n)
                    break;
                key[best] = '0;
            end
            u = best;
            in_tree[u] = 1'b1;
            // Relax only on a strictly lower cost.
            for (v = 0; v < n; v++) begin
                if (!in_tree[v] && graph_cost[u][v] < NO_EDGE && graph_cost[u][v] < key[v]) begin
                    key[v]        = graph_cost[u][v];
                    parent[v]     = u[VERTEX_BITS-1:0];
                    has_parent[v] = 1'b1;
                end
            end
        end

        edges = 0;
        total = 0;
        for (v = 0; v < n; v++) begin
            if (has_parent[v]) begin
                edges++;
                total += int'(key[v]);
            end
        end
        conn = (edges + 1 == n);

        if (edges == 0) begin
            r           = '0;
            r.connected = conn;
            r.last      = 1'b1;
            tree_edges_due = {tree_edges_due, r};
            return;
        end

        // Tree edges go out in ascending child order.
        k = 0;
        for (v = 0; v < n; v++) begin
            if (has_parent[v]) begin
                r.edge_valid     = 1'b1;
                r.parent_vertex  = parent[v];
                r.child_vertex   = v[VERTEX_BITS-1:0];
                r.tree_edge_cost = key[v][COST_BITS-1:0];
                r.total_cost     = total[TOTAL_BITS-1:0];
                r.connected      = conn;
                r.last           = (k + 1 == edges);
                tree_edges_due = {tree_edges_due, r};
                k++;
            end
        end
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            o_fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_mst_result want;
        if (!i_rst_n) begin
            wipe_graph();
            vertex_count_reg = VCOUNT_RESET;
            tree_edges_due.delete();
            o_fail_count   = 0;
            o_results_seen = 0;
        end else begin
            // Compare every accepted result with the oldest prediction.
            if (o_out_valid && !i_out_stall) begin
                o_results_seen++;
                if (tree_edges_due.size() == 0) begin
                    $error("result item arrived with no prediction waiting");
                    o_fail_count++;
                end else begin
                    want = tree_edges_due.pop_front();
                    check_field("edge_valid", 32'(want.edge_valid), 32'(o_edge_valid));
                    check_field("parent_vertex", 32'(want.parent_vertex),
                                32'(o_parent_vertex));
                    check_field("child_vertex", 32'(want.child_vertex), 32'(o_child_vertex));
                    check_field("tree_edge_cost", 32'(want.tree_edge_cost),
                                32'(o_tree_edge_cost));
                    check_field("total_cost", 32'(want.total_cost), 32'(o_total_cost));
                    check_field("connected", 32'(want.connected), 32'(o_connected));
                    check_field("last", 32'(want.last), 32'(o_last));
                end
            end

            // Apply each accepted input item to the shadow graph.
            if (i_in_valid && !o_in_stall) begin
                case (i_mode)
                    MODE_CLEAR: begin
                        wipe_graph();
                    end
                    MODE_ADD: begin
                        if (i_vertex_a != i_vertex_b &&
                            {1'b0, i_edge_cost} < graph_cost[i_vertex_a][i_vertex_b]) begin
                            graph_cost[i_vertex_a][i_vertex_b] = {1'b0, i_edge_cost};
                            graph_cost[i_vertex_b][i_vertex_a] = {1'b0, i_edge_cost};
                        end
                    end
                    MODE_RUN: begin
                        grow_forest();
                    end
                    default: begin
                    end
                endcase
            end

            // Register writes on the configuration port.
            if (psel && penable && pwrite && pready && paddr == ADDR_VERTEX_COUNT)
                vertex_count_reg = pwdata[VCOUNT_BITS-1:0];
        end
        o_pending = tree_edges_due.size();
    end

endmodule

[verif/tb.sv]
`timescale 1ns / 1ps

// Drives graph loads and spanning tree runs into the unit under several vertex
// counts and idling patterns; the checker beside the block judges the results.
module tb;
    import mst_pkg::*;

    // The unused mode code, which the block must ignore.
    localparam logic [1:0] MODE_UNUSED = 2'd3;
    // Cycles to let a clear pass finish before a register write.
    localparam int CLEAR_SETTLE = 1100;
    // Cycles to watch for stray results at the end.
    localparam int TAIL_CYCLES = 2500;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [PADDR_BITS-1:0]  paddr;
    logic [PDATA_BITS-1:0]  pwdata;
    logic [PDATA_BITS-1:0]  prdata;
    logic                   pready;
    logic                   i_in_valid;
    logic                   o_in_stall;
    logic [1:0]             i_mode;
    logic [VERTEX_BITS-1:0] i_vertex_a;
    logic [VERTEX_BITS-1:0] i_vertex_b;
    logic [COST_BITS-1:0]   i_edge_cost;
    logic                   o_out_valid;
    logic                   i_out_stall;
    logic                   o_edge_valid;
    logic [VERTEX_BITS-1:0] o_parent_vertex;
    logic [VERTEX_BITS-1:0] o_child_vertex;
    logic [COST_BITS-1:0]   o_tree_edge_cost;
    logic [TOTAL_BITS-1:0]  o_total_cost;
    logic                   o_connected;
    logic                   o_last;

    int fail_count;
    int pending;
    int results_seen;

    int sender_gap_pct;
    int stall_pct;
    int active_vertices;
    int items_sent;
    int runs_sent;
    int count_writes;

    prim_minimum_spanning_tree_unit dut (.*);

    mst_checker u_checker (
        .*,
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_results_seen (results_seen)
    );

    always #5 i_clk = ~i_clk;

    // The receiver stalls at random at the rate of the current phase.
    always @(negedge i_clk)
        i_out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);

    // Sends one item, with random gaps ahead of it, and returns at the falling
    // edge after it was accepted.
    task automatic send_item(input logic [1:0] mode, input logic [VERTEX_BITS-1:0] a,
                             input logic [VERTEX_BITS-1:0] b,
                             input logic [COST_BITS-1:0] cost);
        while (sender_gap_pct != 0 && $urandom_range(99) < sender_gap_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_mode      <= mode;
        i_vertex_a  <= a;
        i_vertex_b  <= b;
        i_edge_cost <= cost;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
        if (mode != MODE_UNUSED && !(mode == MODE_ADD && a == b))
            items_sent++;
        if (mode == MODE_RUN)
            runs_sent++;
    endtask

    // Holds the sender off until every predicted result has come out.
    task automatic wait_results_done();
        i_in_valid <= 1'b0;
        while (pending != 0)
            @(negedge i_clk);
    endtask

    // Writes the vertex count once the block has gone idle.
    task automatic write_vertex_count(input logic [VCOUNT_BITS-1:0] value);
        wait_results_done();
        repeat (CLEAR_SETTLE) @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_VERTEX_COUNT;
        pwdata  <= {26'($urandom), value};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (value == 0)
            active_vertices = 1;
        else if (value > MAX_VERTICES)
            active_vertices = MAX_VERTICES;
        else
            active_vertices = int'(value);
        count_writes++;
    endtask

    // Mostly in range, now and then any vertex the field can hold.
    function automatic logic [VERTEX_BITS-1:0] pick_vertex();
        if ($urandom_range(9) == 0)
            return VERTEX_BITS'($urandom_range(MAX_VERTICES - 1));
        return VERTEX_BITS'($urandom_range(active_vertices - 1));
    endfunction

    // Random graphs: mostly edge loads followed by a run, plus clears and noise.
    task automatic random_phase(input int budget);
        int done_items;
        int pick;
        int style;
        int edge_loads;
        int j;
        logic [VERTEX_BITS-1:0] a;
        logic [COST_BITS-1:0]   cost;
        done_items = 0;
        while (done_items < budget) begin
            pick = $urandom_range(99);
            if (pick < 10) begin
                // Items the block must ignore: the unused mode and self loops.
                a = VERTEX_BITS'($urandom);
                if ($urandom_range(1))
                    send_item(MODE_UNUSED, a, VERTEX_BITS'($urandom), COST_BITS'($urandom));
                else
                    send_item(MODE_ADD, a, a, COST_BITS'($urandom));
            end else if (pick < 16) begin
                send_item(MODE_CLEAR, VERTEX_BITS'($urandom), VERTEX_BITS'($urandom),
                          COST_BITS'($urandom));
                done_items++;
            end else begin
                // Cost style: full range, a few values that tie, or the extremes.
                style      = $urandom_range(2);
                edge_loads = $urandom_range(1, (2 * active_vertices + 1 < 20) ?
                                               2 * active_vertices + 1 : 20);
                for (j = 0; j < edge_loads; j++) begin
                    case (style)
                        0:       cost = COST_BITS'($urandom);
                        1:       cost = COST_BITS'($urandom_range(3));
                        default: cost = $urandom_range(1) ? '1 : '0;
                    endcase
                    send_item(MODE_ADD, pick_vertex(), pick_vertex(), cost);
                    done_items++;
                end
                send_item(MODE_RUN, VERTEX_BITS'($urandom), VERTEX_BITS'($urandom),
                          COST_BITS'($urandom));
                done_items++;
                if ($urandom_range(4) == 0)
                    wait_results_done();
            end
        end
    endtask

    // Phase plan: vertex count, sender gap rate, receiver stall rate, item budget.
    int phase_count [7]  = '{1, 0, 63, 8, 4, 32, 12};
    int phase_gap [7]    = '{58, 0, 23, 58, 0, 23, 0};
    int phase_stall [7]  = '{0, 58, 23, 0, 58, 23, 0};
    int phase_budget [7] = '{6, 6, 6, 14, 14, 12, 12};

    initial begin
        int p;
        int i;
        i_clk          = 1'b0;
        i_rst_n        = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        i_in_valid     = 1'b0;
        i_mode         = MODE_CLEAR;
        i_vertex_a     = '0;
        i_vertex_b     = '0;
        i_edge_cost    = '0;
        sender_gap_pct = 0;
        stall_pct      = 0;
        items_sent     = 0;
        runs_sent      = 0;
        count_writes   = 0;
        active_vertices = MAX_VERTICES;

        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed test: a graph on six vertices.
        write_vertex_count(6'd6);
        send_item(MODE_ADD, 5'd0, 5'd1, 16'd0);
        send_item(MODE_ADD, 5'd1, 5'd2, 16'hFFFF);
        // A self loop is ignored.
        send_item(MODE_ADD, 5'd2, 5'd2, 16'd9);
        // Stored, but outside the vertices in use.
        send_item(MODE_ADD, 5'd31, 5'd0, 16'd5);
        // A repeated pair keeps the lower cost, in either endpoint order.
        send_item(MODE_ADD, 5'd0, 5'd1, 16'd10);
        send_item(MODE_ADD, 5'd2, 5'd1, 16'd100);
        send_item(MODE_ADD, 5'd3, 5'd4, 16'd7);
        // Equal key for vertex 2 from two parents.
        send_item(MODE_ADD, 5'd0, 5'd2, 16'd100);
        send_item(MODE_UNUSED, 5'd31, 5'd31, 16'hFFFF);
        // Two components and an isolated vertex: the forest restarts twice.
        send_item(MODE_RUN, 5'd0, 5'd0, 16'd0);
        send_item(MODE_ADD, 5'd4, 5'd5, 16'hFFFF);
        send_item(MODE_ADD, 5'd2, 5'd3, 16'hFFFF);
        send_item(MODE_RUN, 5'd31, 5'd31, 16'hFFFF);
        send_item(MODE_CLEAR, 5'd31, 5'd0, 16'hFFFF);
        // Empty graph gives one result with no edge.
        send_item(MODE_RUN, 5'd0, 5'd31, 16'd0);

        // Random phases under different counts and idling patterns.
        for (p = 0; p < 7; p++) begin
            write_vertex_count(VCOUNT_BITS'(phase_count[p]));
            sender_gap_pct = phase_gap[p];
            stall_pct      = phase_stall[p];
            // At full size, one chain of maximum costs gives the largest total.
            if (active_vertices == MAX_VERTICES && p == 2) begin
                send_item(MODE_CLEAR, 5'd0, 5'd0, 16'd0);
                for (i = 0; i < MAX_VERTICES - 1; i++)
                    send_item(MODE_ADD, VERTEX_BITS'(i), VERTEX_BITS'(i + 1), '1);
                send_item(MODE_RUN, 5'd0, 5'd0, 16'd0);
            end
            random_phase(phase_budget[p]);
        end

        wait_results_done();
        repeat (TAIL_CYCLES) @(negedge i_clk);

        $display("Run covered %0d items (%0d spanning tree runs) and %0d checked results",
                 items_sent, runs_sent, results_seen);
        $display("over %0d vertex count settings, including 0, 1 and 63.", count_writes);
        if (fail_count == 0 && pending == 0)
            $display("[prim_minimum_spanning_tree_unit] OK");
        else
            $display("[prim_minimum_spanning_tree_unit] ERROR");
        $finish;
    end

    // Hard stop in case the block hangs.
    initial begin
        #40_000_000;
        $display("[prim_minimum_spanning_tree_unit] ERROR");
        $finish;
    end

endmodule

[prim_minimum_spanning_tree_unit.f]
+incdir+src
src/mst_pkg.sv
src/mst_cost_ram.sv
src/mst_engine.sv
src/prim_minimum_spanning_tree_unit.sv
verif/mst_checker.sv
verif/tb.sv
